/* rtl/core/oqrd_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the order queue.
`timescale 1ns / 1ps
`default_nettype none
package oqrd_pkg;

  // Store geometry
  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // Word field widths
  localparam int OP_W  = 3;
  localparam int ID_W  = 32;
  localparam int POS_W = 6;
  localparam int ST_W  = 4;
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Command codes
  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 3'd0,
    OP_DEQ   = 3'd1,
    OP_SHOW  = 3'd2,
    OP_REV   = 3'd3,
    OP_DEL   = 3'd4,
    OP_CLEAR = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_ENQ        = 4'd0,
    ST_DEQ        = 4'd1,
    ST_EMPTY      = 4'd2,
    ST_REV        = 4'd3,
    ST_DEL        = 4'd4,
    ST_CLR        = 4'd5,
    ST_SHOW       = 4'd6,
    ST_SHOW_EMPTY = 4'd7,
    ST_FULL       = 4'd8
  } status_t;

  // Logical index fed to the slot unit
  typedef enum logic [2:0] {
    SEL_ZERO   = 3'd0,
    SEL_ONE    = 3'd1,
    SEL_OCC    = 3'd2,
    SEL_OCC_M1 = 3'd3,
    SEL_IDX    = 3'd4,
    SEL_IDX_P1 = 3'd5
  } slot_sel_t;

  // Source of a result value
  typedef enum logic [1:0] {
    VAL_ZERO  = 2'd0,
    VAL_ID    = 2'd1,
    VAL_RDATA = 2'd2,
    VAL_POS   = 2'd3
  } val_src_t;

  // Store write data source
  typedef enum logic {
    WR_ID    = 1'b0,
    WR_RDATA = 1'b1
  } wr_src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      load_cmd;
    slot_sel_t slot_sel;
    logic      mem_rd;
    logic      mem_wr;
    wr_src_t   wr_src;
    logic      idx_load_pos;
    logic      idx_clear;
    logic      idx_inc;
    logic      occ_inc;
    logic      occ_dec;
    logic      front_load;
    logic      rev_toggle;
    logic      clear_all;
    logic      out_load;
    status_t   out_status;
    val_src_t  out_val_src;
    logic      out_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic rev_ok;
    logic del_hit;
    logic del_shift;
    logic shift_more;
    logic show_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/order_queue_with_reverse_and_delete_core.sv */
// Top level of the order queue: controller, datapath and checks.
//
// Bounded queue of up to DEPTH 32-bit order ids in a single-port circular store with
// a direction flag. One input word is one command; results leave through a
// registered output word, and the next command is taken while a result waits.
// Commands are handled one at a time. Enqueue, reverse, clear and the empty cases end
// in the decode state; dequeue reads the front first. Show reads the entries in turn,
// and delete at position p moves each later entry down by a read and a write, as the
// store port does one read or one write per cycle. A stalled output holds the command.
// Reading a slot never written is impossible with the command set; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module order_queue_with_reverse_and_delete_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [oqrd_pkg::OP_W-1:0]  op,
  input  wire logic [oqrd_pkg::ID_W-1:0]  entry_id,
  input  wire logic [oqrd_pkg::POS_W-1:0] position,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [oqrd_pkg::ST_W-1:0]      status,
  output logic [oqrd_pkg::ID_W-1:0]      value,
  output logic                           last
);
  import oqrd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  oqrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  oqrd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .entry_id  (entry_id),
    .position  (position),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .value     (value),
    .last      (last),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Single store port: never read and write together
  a_one_port: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("store read and write in the same cycle");

  // Never overwrite a result that has not been taken
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten");

  // Occupancy stays within bounds
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    cmd.occ_inc |-> !stat.full)
    else $error("enqueue into full store");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd.occ_dec |-> !stat.empty)
    else $error("removal from empty store");

endmodule
`default_nettype wire

/* rtl/core/oqrd_dpath.sv */
// Datapath of the order queue: circular store, pointers, slot unit and result register.
`timescale 1ns / 1ps
`default_nettype none
module oqrd_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [oqrd_pkg::OP_W-1:0]  op,
  input  wire logic [oqrd_pkg::ID_W-1:0]  entry_id,
  input  wire logic [oqrd_pkg::POS_W-1:0] position,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic [oqrd_pkg::ST_W-1:0]      status,
  output logic [oqrd_pkg::ID_W-1:0]      value,
  output logic                           last,
  input  wire oqrd_pkg::dp_cmd_t          cmd,
  output oqrd_pkg::dp_stat_t              stat
);
  import oqrd_pkg::*;

  logic [OP_W-1:0]  op_r;
  logic [ID_W-1:0]  id_r;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] idx;
  logic [PTR_W-1:0] front;
  logic [CNT_W-1:0] occ;
  logic             rev;
  logic [ID_W-1:0]  mem [DEPTH];
  logic [ID_W-1:0]  rdata;

  logic [CNT_W-1:0] li;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_wrap;
  logic [PTR_W-1:0] slot;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] occ_ext;
  logic [CMP_W-1:0] idx_ext;
  logic [ID_W-1:0]  wdata;
  logic [ID_W-1:0]  out_val;

  // Latch the command word
  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      op_r  <= op;
      id_r  <= entry_id;
      pos_r <= position;
    end
  end

  // Pick the logical index for the slot unit
  always_comb begin
    unique case (cmd.slot_sel)
      SEL_ZERO:   li = '0;
      SEL_ONE:    li = CNT_W'(1);
      SEL_OCC:    li = occ;
      SEL_OCC_M1: li = occ - CNT_W'(1);
      SEL_IDX:    li = idx;
      SEL_IDX_P1: li = idx + CNT_W'(1);
      default:    li = '0;
    endcase
  end

  // Map logical index to physical slot, walking up or down the ring
  always_comb begin
    if (rev) begin
      sum = SUM_W'(front) + SUM_W'(DEPTH) - SUM_W'(li);
    end else begin
      sum = SUM_W'(front) + SUM_W'(li);
    end
    sum_wrap = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
    slot     = sum_wrap[PTR_W-1:0];
  end

  // Store write and registered read
  assign wdata = (cmd.wr_src == WR_RDATA) ? rdata : id_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[slot] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rdata <= mem[slot];
    end
  end

  // Walk index
  always_ff @(posedge clk) begin
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_load_pos) begin
      idx <= CNT_W'(pos_r);
    end else if (cmd.idx_inc) begin
      idx <= idx + CNT_W'(1);
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      front <= '0;
      occ   <= '0;
      rev   <= 1'b0;
    end else begin
      if (cmd.front_load) begin
        front <= slot;
      end
      if (cmd.occ_inc) begin
        occ <= occ + CNT_W'(1);
      end else if (cmd.occ_dec) begin
        occ <= occ - CNT_W'(1);
      end
      if (cmd.rev_toggle) begin
        rev <= ~rev;
      end
    end
  end

  // Result value select
  always_comb begin
    unique case (cmd.out_val_src)
      VAL_ZERO:  out_val = '0;
      VAL_ID:    out_val = id_r;
      VAL_RDATA: out_val = rdata;
      VAL_POS:   out_val = ID_W'(pos_r);
      default:   out_val = '0;
    endcase
  end

  // Result register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_status;
      value  <= out_val;
      last   <= cmd.out_last;
    end
  end

  // Status back to the controller
  assign pos_ext = CMP_W'(pos_r);
  assign occ_ext = CMP_W'(occ);
  assign idx_ext = CMP_W'(idx);

  always_comb begin
    stat.op         = op_t'(op_r);
    stat.empty      = (occ == '0);
    stat.full       = (occ == CNT_W'(DEPTH));
    stat.rev_ok     = (occ >= CNT_W'(2));
    stat.del_hit    = (pos_ext < occ_ext);
    stat.del_shift  = ((pos_ext + CMP_W'(1)) < occ_ext);
    stat.shift_more = ((idx_ext + CMP_W'(2)) < occ_ext);
    stat.show_last  = ((idx_ext + CMP_W'(1)) == occ_ext);
    stat.out_free   = ~out_valid | out_ready;
  end

endmodule
`default_nettype wire

/* rtl/core/oqrd_ctrl.sv */
// Controller of the order queue: command sequencing state machine.
`timescale 1ns / 1ps
`default_nettype none
module oqrd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire oqrd_pkg::dp_stat_t stat,
  output oqrd_pkg::dp_cmd_t       cmd
);
  import oqrd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_DEQ_OUT  = 8'b0000_0100,
    S_SHOW_OUT = 8'b0000_1000,
    S_SHOW_RD  = 8'b0001_0000,
    S_DEL_RD   = 8'b0010_0000,
    S_DEL_WR   = 8'b0100_0000,
    S_DEL_OUT  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence each command
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_cmd = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_ENQ: begin
            if (stat.out_free) begin
              cmd.out_load    = 1'b1;
              cmd.out_val_src = VAL_ID;
              cmd.out_last    = 1'b1;
              if (stat.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.out_status = ST_ENQ;
                cmd.slot_sel   = SEL_OCC;
                cmd.mem_wr     = 1'b1;
                cmd.wr_src     = WR_ID;
                cmd.occ_inc    = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          OP_DEQ: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                cmd.out_load    = 1'b1;
                cmd.out_status  = ST_EMPTY;
                cmd.out_val_src = VAL_ZERO;
                cmd.out_last    = 1'b1;
                state_next      = S_IDLE;
              end
            end else begin
              cmd.slot_sel = SEL_ZERO;
              cmd.mem_rd   = 1'b1;
              state_next   = S_DEQ_OUT;
            end
          end
          OP_SHOW: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                cmd.out_load    = 1'b1;
                cmd.out_status  = ST_SHOW_EMPTY;
                cmd.out_val_src = VAL_ZERO;
                cmd.out_last    = 1'b1;
                state_next      = S_IDLE;
              end
            end else begin
              cmd.slot_sel  = SEL_ZERO;
              cmd.mem_rd    = 1'b1;
              cmd.idx_clear = 1'b1;
              state_next    = S_SHOW_OUT;
            end
          end
          OP_REV: begin
            if (stat.out_free) begin
              cmd.out_load    = 1'b1;
              cmd.out_status  = ST_REV;
              cmd.out_val_src = VAL_ZERO;
              cmd.out_last    = 1'b1;
              if (stat.rev_ok) begin
                cmd.slot_sel   = SEL_OCC_M1;
                cmd.front_load = 1'b1;
                cmd.rev_toggle = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          OP_DEL: begin
            if (stat.del_shift) begin
              cmd.idx_load_pos = 1'b1;
              state_next       = S_DEL_RD;
            end else begin
              state_next = S_DEL_OUT;
            end
          end
          OP_CLEAR: begin
            if (stat.out_free) begin
              cmd.out_load    = 1'b1;
              cmd.out_status  = ST_CLR;
              cmd.out_val_src = VAL_ZERO;
              cmd.out_last    = 1'b1;
              cmd.clear_all   = 1'b1;
              state_next      = S_IDLE;
            end
          end
          // Drop unused codes without a result
          default: state_next = S_IDLE;
        endcase
      end
      S_DEQ_OUT: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = ST_DEQ;
          cmd.out_val_src = VAL_RDATA;
          cmd.out_last    = 1'b1;
          cmd.slot_sel    = SEL_ONE;
          cmd.front_load  = 1'b1;
          cmd.occ_dec     = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SHOW_OUT: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = ST_SHOW;
          cmd.out_val_src = VAL_RDATA;
          cmd.out_last    = stat.show_last;
          if (stat.show_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_SHOW_RD;
          end
        end
      end
      S_SHOW_RD: begin
        cmd.slot_sel = SEL_IDX;
        cmd.mem_rd   = 1'b1;
        state_next   = S_SHOW_OUT;
      end
      S_DEL_RD: begin
        cmd.slot_sel = SEL_IDX_P1;
        cmd.mem_rd   = 1'b1;
        state_next   = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd.slot_sel = SEL_IDX;
        cmd.mem_wr   = 1'b1;
        cmd.wr_src   = WR_RDATA;
        cmd.idx_inc  = 1'b1;
        state_next   = stat.shift_more ? S_DEL_RD : S_DEL_OUT;
      end
      S_DEL_OUT: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = ST_DEL;
          cmd.out_val_src = VAL_POS;
          cmd.out_last    = 1'b1;
          cmd.occ_dec     = stat.del_hit;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* dv/oqrd_result_checker.sv */
// Order queue result checker: mirrors the queue on accepted command words and checks results.
`timescale 1ns / 1ps
module oqrd_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [oqrd_pkg::OP_W-1:0]  op,
  input  logic [oqrd_pkg::ID_W-1:0]  entry_id,
  input  logic [oqrd_pkg::POS_W-1:0] position,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [oqrd_pkg::ST_W-1:0]  status,
  input  logic [oqrd_pkg::ID_W-1:0]  value,
  input  logic                       last,
  output int                         fail_count,
  output int                         results_pending
);
  import oqrd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    status_t         st;
    logic [ID_W-1:0] val;
    logic            fin;
  } result_word_t;

  // Mirror of the circular store: ids, logical front slot, fill level, direction
  logic [ID_W-1:0] held_ids [DEPTH];
  int              head_slot;
  int              held_count;
  bit              flipped;

  result_word_t    awaited_words [$];
  int              reported;

  // Map a logical index from the front onto a physical slot
  function automatic int slot_at(int idx);
    int i;
    i = idx % DEPTH;
    if (flipped) return (head_slot + DEPTH - i) % DEPTH;
    return (head_slot + i) % DEPTH;
  endfunction

  function automatic void await_word(status_t st, logic [ID_W-1:0] val, logic fin);
    result_word_t w;
    w.st  = st;
    w.val = val;
    w.fin = fin;
    awaited_words.push_back(w);
  endfunction

  // Update the mirror for one command and queue the result words it yields
  task automatic apply_command(logic [OP_W-1:0] code, logic [ID_W-1:0] id,
                               logic [POS_W-1:0] pos);
    int              i;
    logic [ID_W-1:0] front_id;
    case (code)
      OP_ENQ: begin
        if (held_count >= DEPTH) begin
          await_word(ST_FULL, id, 1'b1);
        end else begin
          held_ids[slot_at(held_count)] = id;
          held_count++;
          await_word(ST_ENQ, id, 1'b1);
        end
      end
      OP_DEQ: begin
        if (held_count == 0) begin
          await_word(ST_EMPTY, '0, 1'b1);
        end else begin
          front_id   = held_ids[slot_at(0)];
          head_slot  = slot_at(1);
          held_count--;
          await_word(ST_DEQ, front_id, 1'b1);
        end
      end
      OP_SHOW: begin
        if (held_count == 0) begin
          await_word(ST_SHOW_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < held_count; i++)
            await_word(ST_SHOW, held_ids[slot_at(i)], (i + 1 == held_count));
        end
      end
      OP_REV: begin
        // fewer than two entries: nothing moves, still acknowledged
        if (held_count >= 2) begin
          head_slot = slot_at(held_count - 1);
          flipped   = !flipped;
        end
        await_word(ST_REV, '0, 1'b1);
      end
      OP_DEL: begin
        // out-of-range index is acknowledged exactly like a hit
        if (int'(pos) < held_count) begin
          for (i = int'(pos); i + 1 < held_count; i++)
            held_ids[slot_at(i)] = held_ids[slot_at(i + 1)];
          held_count--;
        end
        await_word(ST_DEL, ID_W'(pos), 1'b1);
      end
      OP_CLEAR: begin
        held_count = 0;
        head_slot  = 0;
        flipped    = 1'b0;
        await_word(ST_CLR, '0, 1'b1);
      end
      default: begin
        // spare codes: no state change, no result
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    result_word_t want;
    if (rst) begin
      held_count = 0;
      head_slot  = 0;
      flipped    = 1'b0;
      fail_count = 0;
      reported   = 0;
      awaited_words.delete();
    end else begin
      // predict on every accepted command word
      if (in_valid && in_ready) apply_command(op, entry_id, position);

      // compare every accepted result word with the oldest prediction
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          fail_count++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("unexpected result word: status %0d value %h last %0d",
                     status, value, last);
          end
        end else begin
          want = awaited_words.pop_front();
          if (status !== want.st || value !== want.val || last !== want.fin) begin
            fail_count++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("result mismatch: expected status %0d value %h last %0d,",
                       want.st, want.val, want.fin,
                       " got status %0d value %h last %0d", status, value, last);
            end
          end
        end
      end
    end
    results_pending <= awaited_words.size();
  end

endmodule

/* dv/testbench.sv */
// Order queue regression top: clock, reset, command stimulus, receiver pacing and verdict.
`timescale 1ns / 1ps
module testbench;
  import oqrd_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam int RESET_CYCLES    = 11;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 2 * DEPTH + 8;
  localparam int QUIET_LIMIT     = 3000;
  localparam int ITEMS_PER_PHASE = 24;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [OP_W-1:0]  op = '0;
  logic [ID_W-1:0]  entry_id = '0;
  logic [POS_W-1:0] position = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ST_W-1:0]  status;
  logic [ID_W-1:0]  value;
  logic             last;

  int   send_idle_pct = 11;
  int   recv_idle_pct = 66;
  logic hold_request = 1'b0;
  int   fail_count;
  int   results_pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  order_queue_with_reverse_and_delete_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .entry_id  (entry_id),
    .position  (position),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .value     (value),
    .last      (last)
  );

  oqrd_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .entry_id        (entry_id),
    .position        (position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .value           (value),
    .last            (last),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // Offer one command word after a random gap; return once it is taken
  task automatic send_command(logic [OP_W-1:0] code, logic [ID_W-1:0] id,
                              logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    entry_id <= id;
    position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Random command mix, enqueue-heavy so the store fills and drains repeatedly
  task automatic run_phase(int s_idle, int r_idle, bit with_hold);
    int               counted;
    int               pick;
    logic [OP_W-1:0]  code;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] pos;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    counted = 0;
    while (counted < ITEMS_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 36)      code = OP_ENQ;
      else if (pick < 50) code = OP_DEQ;
      else if (pick < 60) code = OP_SHOW;
      else if (pick < 70) code = OP_REV;
      else if (pick < 88) code = OP_DEL;
      else if (pick < 91) code = OP_CLEAR;
      else                code = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;

      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       id = 32'h8000_0000;
          1:       id = 32'h7fff_ffff;
          2:       id = '0;
          default: id = '1;
        endcase
      end else begin
        id = $urandom;
      end

      // mostly indexes that can hit, some beyond any possible fill level
      if ($urandom_range(6) == 0) pos = POS_W'($urandom_range(63, DEPTH));
      else                        pos = POS_W'($urandom_range(DEPTH - 1));

      // start the long receiver hold while words keep coming
      if (with_hold && counted == 10) hold_request <= 1'b1;

      send_command(code, id, pos);
      if (code != OP_SPARE_A && code != OP_SPARE_B) counted++;
    end
  endtask

  // Receiver pacing, with one long hold-off counted here
  initial begin : receiver
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // End the run when no word moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("order_queue_with_reverse_and_delete_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    int k;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty queue corners
    send_command(OP_SHOW, '0, '0);
    send_command(OP_DEQ, '0, '0);
    send_command(OP_REV, '0, '0);
    send_command(OP_DEL, '0, 6'd63);
    send_command(OP_CLEAR, '0, '0);

    // single entry, then id extremes
    send_command(OP_ENQ, 32'h8000_0000, '0);
    send_command(OP_REV, '0, '0);
    send_command(OP_SHOW, '0, '0);
    send_command(OP_ENQ, 32'h7fff_ffff, '0);
    send_command(OP_ENQ, '1, '0);
    send_command(OP_ENQ, '0, '0);

    // fill up, then push once more to get a full reject
    for (k = 4; k < DEPTH; k++) send_command(OP_ENQ, $urandom, '0);
    send_command(OP_ENQ, 32'h5a5a_a5a5, '0);
    send_command(OP_SHOW, '0, '0);
    send_command(OP_REV, '0, '0);
    send_command(OP_DEL, '0, '0);
    send_command(OP_DEL, '0, POS_W'(DEPTH - 2));
    send_command(OP_DEQ, '0, '0);
    send_command(OP_SPARE_A, '1, '1);
    send_command(OP_SPARE_B, '0, '0);
    send_command(OP_CLEAR, '0, '0);

    // random part: sender light/receiver heavy, swapped, then full rate
    run_phase(11, 66, 1'b1);
    run_phase(66, 11, 1'b0);
    run_phase(0, 0, 1'b0);
    in_valid <= 1'b0;

    // drain outstanding results, then let the block settle
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && results_pending == 0)
      $display("order_queue_with_reverse_and_delete_core regression: pass");
    else
      $display("order_queue_with_reverse_and_delete_core regression: fail");
    $finish;
  end

endmodule

/* order_queue_with_reverse_and_delete_core.f */
rtl/core/oqrd_pkg.sv
rtl/core/oqrd_dpath.sv
rtl/core/oqrd_ctrl.sv
rtl/core/order_queue_with_reverse_and_delete_core.sv
dv/oqrd_result_checker.sv
dv/testbench.sv
